### rtl/core/ubxack_pkg.sv
// Shared types and constants of the acknowledge packet matcher.
`timescale 1ns / 1ps

package ubxack_pkg;

  // Action codes of an input beat.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ACKED_CLASS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACKED_ID      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

  // Register reset values.
  localparam logic [7:0]  ACKED_CLASS_RST   = 8'h06;
  localparam logic [7:0]  ACKED_ID_RST      = 8'h00;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd3000;

  // Fixed bytes of the acknowledge packet.
  localparam logic [7:0] SYNC_1    = 8'hB5;
  localparam logic [7:0] SYNC_2    = 8'h62;
  localparam logic [7:0] ACK_CLASS = 8'h05;
  localparam logic [7:0] ACK_ID    = 8'h01;
  localparam logic [7:0] LEN_LO    = 8'h02;
  localparam logic [7:0] LEN_HI    = 8'h00;

  // Packet byte positions.
  localparam logic [3:0] PACKET_LEN   = 4'd10;
  localparam logic [3:0] POS_CLASS    = 4'd2;
  localparam logic [3:0] POS_LEN_LO   = 4'd4;
  localparam logic [3:0] POS_LEN_HI   = 4'd5;
  localparam logic [3:0] POS_ACKED_CL = 4'd6;
  localparam logic [3:0] POS_ACKED_ID = 4'd7;
  localparam logic [3:0] POS_CK_A     = 4'd8;
  localparam logic [3:0] POS_CK_B     = 4'd9;

  // Result status codes.
  localparam logic STATUS_ACKED    = 1'b0;
  localparam logic STATUS_TIMEDOUT = 1'b1;

  // Matcher state.
  typedef struct packed {
    logic        armed;
    logic [3:0]  match_index;
    logic [15:0] elapsed_ticks;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
  } match_state_t;

  // Result of one processed beat.
  typedef struct packed {
    logic valid;
    logic status;
  } step_res_t;

endpackage

### rtl/core/ubxack_step.sv
// Next-state and result logic for one input beat of the matcher.
`timescale 1ns / 1ps

module ubxack_step (
  input  logic [1:0]                 action,
  input  logic [7:0]                 rx_byte,
  input  logic [7:0]                 acked_class,
  input  logic [7:0]                 acked_id,
  input  logic [15:0]                timeout_ticks,
  input  ubxack_pkg::match_state_t   st,
  output ubxack_pkg::match_state_t   st_nxt,
  output ubxack_pkg::step_res_t      res
);
  import ubxack_pkg::*;

  logic [7:0]  exp_byte;
  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [15:0] elapsed_inc;
  logic        in_sum_range;

  // Expected byte at the current match position.
  always_comb begin
    unique case (st.match_index)
      4'd0:         exp_byte = SYNC_1;
      4'd1:         exp_byte = SYNC_2;
      POS_CLASS:    exp_byte = ACK_CLASS;
      4'd3:         exp_byte = ACK_ID;
      POS_LEN_LO:   exp_byte = LEN_LO;
      POS_LEN_HI:   exp_byte = LEN_HI;
      POS_ACKED_CL: exp_byte = acked_class;
      POS_ACKED_ID: exp_byte = acked_id;
      POS_CK_A:     exp_byte = st.sum_a;
      POS_CK_B:     exp_byte = st.sum_b;
      default:      exp_byte = 8'h00;
    endcase
  end

  // Running checksum sums and the saturating tick count.
  assign sum_a_add    = st.sum_a + rx_byte;
  assign sum_b_add    = st.sum_b + sum_a_add;
  assign in_sum_range = (st.match_index >= POS_CLASS) && (st.match_index <= POS_ACKED_ID);
  assign elapsed_inc  = (st.elapsed_ticks == 16'hFFFF) ? st.elapsed_ticks
                                                        : st.elapsed_ticks + 16'd1;

  // State update and result for the beat.
  always_comb begin
    st_nxt = st;
    res    = '0;
    unique case (action)
      ACT_START: begin
        st_nxt.armed         = 1'b1;
        st_nxt.elapsed_ticks = '0;
        st_nxt.match_index   = '0;
        st_nxt.sum_a         = '0;
        st_nxt.sum_b         = '0;
      end
      ACT_BYTE: begin
        if (st.armed) begin
          if ((st.match_index < PACKET_LEN) && (rx_byte == exp_byte)) begin
            if (in_sum_range) begin
              st_nxt.sum_a = sum_a_add;
              st_nxt.sum_b = sum_b_add;
            end
            if (st.match_index == POS_CK_B) begin
              // Whole packet seen: report success and disarm.
              st_nxt.armed       = 1'b0;
              st_nxt.match_index = '0;
              st_nxt.sum_a       = '0;
              st_nxt.sum_b       = '0;
              res.valid          = 1'b1;
              res.status         = STATUS_ACKED;
            end else begin
              st_nxt.match_index = st.match_index + 4'd1;
            end
          end else begin
            // A mismatching byte restarts the search and is dropped.
            st_nxt.match_index = '0;
            st_nxt.sum_a       = '0;
            st_nxt.sum_b       = '0;
          end
        end
      end
      ACT_TICK: begin
        if (st.armed) begin
          st_nxt.elapsed_ticks = elapsed_inc;
          if (elapsed_inc > timeout_ticks) begin
            st_nxt.armed       = 1'b0;
            st_nxt.match_index = '0;
            st_nxt.sum_a       = '0;
            st_nxt.sum_b       = '0;
            res.valid          = 1'b1;
            res.status         = STATUS_TIMEDOUT;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/ubxack_out_reg.sv
// Result register that holds one status beat until the consumer takes it.
`timescale 1ns / 1ps

module ubxack_out_reg (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  logic load_status,
  output logic can_load,
  output logic out_valid,
  input  logic out_ready,
  output logic out_status
);

  logic out_valid_r;
  logic out_valid_nxt;
  logic out_status_r;

  // A new beat may enter when the register is empty or is being drained.
  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= load_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

### rtl/core/ubx_ack_matcher.sv
// Top level of the acknowledge packet matcher.
`timescale 1ns / 1ps

// The matcher takes one beat per cycle: a start, a received byte or a
// millisecond tick. Each beat is captured in an input register and processed
// from there by a single pass of compare and counter logic, which
// updates the match state and may load one status beat into the result
// register, so a status passes the input register and then the result register.
// The sustained rate is one beat per clock; the only stall comes from the result
// register, when a status is produced while the previous one is not yet taken.
// The user must write configuration registers only while idle; not enforced here.

module ubx_ack_matcher (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_action,
  input  logic [7:0]                          in_rx_byte,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_status,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [ubxack_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ubxack_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ubxack_pkg::*;

  logic         inq_valid_r;
  logic [1:0]   inq_action_r;
  logic [7:0]   inq_rx_byte_r;
  logic [7:0]   acked_class_r;
  logic [7:0]   acked_id_r;
  logic [15:0]  timeout_ticks_r;
  match_state_t st_r;
  match_state_t st_nxt;
  step_res_t    res;
  logic         can_load;
  logic         fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acked_class_r   <= ACKED_CLASS_RST;
      acked_id_r      <= ACKED_ID_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACKED_CLASS:   acked_class_r   <= cfg_wdata[7:0];
        REG_ACKED_ID:      acked_id_r      <= cfg_wdata[7:0];
        REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The held beat is processed unless its status cannot enter the result register.
  assign fire     = inq_valid_r && (!res.valid || can_load);
  assign in_ready = !inq_valid_r || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_ready) begin
      inq_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq_action_r  <= in_action;
      inq_rx_byte_r <= in_rx_byte;
    end
  end

  // Match state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  ubxack_step u_step (
    .action        (inq_action_r),
    .rx_byte       (inq_rx_byte_r),
    .acked_class   (acked_class_r),
    .acked_id      (acked_id_r),
    .timeout_ticks (timeout_ticks_r),
    .st            (st_r),
    .st_nxt        (st_nxt),
    .res           (res)
  );

  ubxack_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (fire && res.valid),
    .load_status (res.status),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status)
  );

`ifndef NO_ASSERTIONS
  // The match position never runs past the last packet byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r.match_index <= POS_CK_B)
    else $error("match index out of range");

  // While disarmed, the match position and checksum sums are clear.
  assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.armed |-> (st_r.match_index == 4'd0 && st_r.sum_a == 8'd0 && st_r.sum_b == 8'd0))
    else $error("stale match state while disarmed");

  // Every reported status disarms the matcher.
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.valid) |=> (!st_r.armed && out_valid))
    else $error("status reported without disarming");

  // Elapsed time only grows, except when a start beat restarts the wait.
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && inq_action_r != ACT_START) |=> (st_r.elapsed_ticks >= $past(st_r.elapsed_ticks)))
    else $error("elapsed count went backward");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the acknowledge packet matcher.
`timescale 1ns / 1ps

module tb_top;
  import ubxack_pkg::*;

  // Codes the package leaves unnamed: the spare action and the spare register slot.
  localparam logic [1:0]           ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_action = ACT_TICK;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_status;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ACKED_CLASS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Beats waiting to be driven, and the statuses the matcher still owes us.
  beat_t beat_q[$];
  logic  pending_status[$];
  int    mismatch_cnt = 0;
  logic  no_gaps = 1'b0;

  // Tracked copy of the register file.
  logic [7:0]  cfg_class   = ACKED_CLASS_RST;
  logic [7:0]  cfg_id      = ACKED_ID_RST;
  logic [15:0] cfg_timeout = TIMEOUT_TICKS_RST;

  // Tracked copy of the matcher state.
  logic        trk_armed   = 1'b0;
  logic [3:0]  trk_idx     = '0;
  logic [15:0] trk_elapsed = '0;
  logic [7:0]  trk_sum_a   = '0;
  logic [7:0]  trk_sum_b   = '0;

  ubx_ack_matcher u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Builds the full acknowledge packet, byte 0 in the low bits, checksum included.
  function automatic logic [79:0] ack_packet(input logic [7:0] cls, input logic [7:0] id);
    logic [79:0] pkt;
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    int          k;
    pkt = {16'h0000, id, cls, LEN_HI, LEN_LO, ACK_ID, ACK_CLASS, SYNC_2, SYNC_1};
    ck_a = 8'h00;
    ck_b = 8'h00;
    for (k = POS_CLASS; k <= POS_ACKED_ID; k++) begin
      ck_a = ck_a + pkt[8*k +: 8];
      ck_b = ck_b + ck_a;
    end
    pkt[8*POS_CK_A +: 8] = ck_a;
    pkt[8*POS_CK_B +: 8] = ck_b;
    return pkt;
  endfunction

  // Advances the tracked matcher by one accepted beat and queues any status it owes.
  task automatic track_beat(input logic [1:0] act, input logic [7:0] rx);
    logic [79:0] pkt;
    logic [7:0]  want;
    pkt = ack_packet(cfg_class, cfg_id);
    case (act)
      ACT_START: begin
        trk_armed = 1'b1;
        trk_elapsed = '0;
        {trk_idx, trk_sum_a, trk_sum_b} = '0;
      end
      ACT_BYTE: begin
        if (trk_armed) begin
          if (trk_idx == POS_CK_A) want = trk_sum_a;
          else if (trk_idx == POS_CK_B) want = trk_sum_b;
          else want = pkt[8*trk_idx +: 8];
          if (trk_idx < PACKET_LEN && rx == want) begin
            if (trk_idx >= POS_CLASS && trk_idx <= POS_ACKED_ID) begin
              trk_sum_a = trk_sum_a + rx;
              trk_sum_b = trk_sum_b + trk_sum_a;
            end
            trk_idx = trk_idx + 4'd1;
            if (trk_idx >= PACKET_LEN) begin
              trk_armed = 1'b0;
              {trk_idx, trk_sum_a, trk_sum_b} = '0;
              pending_status.push_back(STATUS_ACKED);
            end
          end else begin
            // A wrong byte drops the partial match and is itself consumed.
            {trk_idx, trk_sum_a, trk_sum_b} = '0;
          end
        end
      end
      ACT_TICK: begin
        if (trk_armed) begin
          if (trk_elapsed != 16'hFFFF) trk_elapsed = trk_elapsed + 16'd1;
          if (trk_elapsed > cfg_timeout) begin
            trk_armed = 1'b0;
            {trk_idx, trk_sum_a, trk_sum_b} = '0;
            pending_status.push_back(STATUS_TIMEDOUT);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Driver: sends queued beats in bursts separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  beat_t next_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_beat(in_action, in_rx_byte);
      if (in_valid && !in_ready) begin
        // Hold the current beat until it is taken.
      end else if (beat_q.size() != 0 && (gap_left == 0 || no_gaps)) begin
        next_beat = beat_q.pop_front();
        in_valid <= 1'b1;
        in_action <= next_beat.action;
        in_rx_byte <= next_beat.rx_byte;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Monitor: checks each status beat and stalls the result channel in shifting modes.
  int   ready_mode = 0;
  int   ready_left = 0;
  int   ready_tick = 0;
  logic want_status;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: status beat %0d with nothing expected", $time, out_status);
          mismatch_cnt++;
        end else begin
          want_status = pending_status.pop_front();
          if (out_status !== want_status) begin
            if (mismatch_cnt < 10)
              $display("%0t: status mismatch, expected %0d, got %0d",
                       $time, want_status, out_status);
            mismatch_cnt++;
          end
        end
      end
      if (ready_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_left = $urandom_range(20, 300);
      end else begin
        ready_left--;
      end
      ready_tick++;
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= (ready_tick % 4 == 0);
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  task automatic push_beat(input logic [1:0] act, input logic [7:0] rx);
    beat_q.push_back({act, rx});
  endtask

  // Waits until every beat is taken and every status has come, then lets the pipe drain.
  task automatic settle();
    while (beat_q.size() != 0 || in_valid) @(negedge clk);
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes one register and mirrors the write in the tracked copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ACKED_CLASS:   cfg_class = data[7:0];
      REG_ACKED_ID:      cfg_id = data[7:0];
      REG_TIMEOUT_TICKS: cfg_timeout = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed packets with random ticks, some corrupted, plus random noise.
  task automatic gen_traffic(input int n);
    int          sent;
    int          k;
    int          bad_pos;
    logic [79:0] pkt;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [7:0]  b;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(0, 99);
      if (k < 65) begin
        if ($urandom_range(0, 9) < 8) begin
          push_beat(ACT_START, 8'($urandom));
          sent++;
        end
        cls = ($urandom_range(0, 9) < 8) ? cfg_class : 8'($urandom);
        id = ($urandom_range(0, 9) < 8) ? cfg_id : 8'($urandom);
        pkt = ack_packet(cls, id);
        bad_pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 10;
        for (k = 0; k < 10; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            push_beat(ACT_TICK, 8'($urandom));
            sent++;
          end
          b = pkt[8*k +: 8];
          if (k == bad_pos) b = b ^ 8'(1 << $urandom_range(0, 7));
          push_beat(ACT_BYTE, b);
          sent++;
        end
      end else if (k < 85) begin
        bad_pos = $urandom_range(1, (cfg_timeout < 40) ? int'(cfg_timeout) + 2 : 40);
        repeat (bad_pos) push_beat(ACT_TICK, 8'($urandom));
        sent += bad_pos;
      end else begin
        push_beat(2'($urandom_range(0, 3)), 8'($urandom));
        sent++;
      end
    end
  endtask

  // Stimulus sequence.
  initial begin
    logic [79:0] pkt;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] tmo;
    int          k;
    int          p;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part on the reset register values.
    // Beats while disarmed, and the spare action, are ignored.
    push_beat(ACT_TICK, 8'h00);
    push_beat(ACT_BYTE, SYNC_1);
    push_beat(ACT_UNUSED, 8'hFF);
    push_beat(ACT_START, 8'hFF);
    // A repeated first sync byte breaks the match and is not reused.
    push_beat(ACT_BYTE, SYNC_1);
    push_beat(ACT_BYTE, SYNC_1);
    push_beat(ACT_BYTE, SYNC_2);
    push_beat(ACT_UNUSED, 8'h00);
    pkt = ack_packet(cfg_class, cfg_id);
    for (k = 0; k < 10; k++) begin
      if (k == 5) push_beat(ACT_TICK, 8'hFF);
      push_beat(ACT_BYTE, pkt[8*k +: 8]);
    end
    // A start while armed restarts the wait.
    push_beat(ACT_START, 8'h00);
    push_beat(ACT_BYTE, SYNC_1);
    push_beat(ACT_START, 8'hA5);
    settle();

    // Short timeout: the failure comes on the tick past the limit.
    no_gaps = 1'b1;
    write_reg(REG_TIMEOUT_TICKS, 16'd5);
    push_beat(ACT_START, 8'h00);
    repeat (6) push_beat(ACT_TICK, 8'($urandom));
    settle();

    // Lowering the limit while armed takes effect on the next tick.
    push_beat(ACT_START, 8'h00);
    repeat (3) push_beat(ACT_TICK, 8'($urandom));
    settle();
    write_reg(REG_TIMEOUT_TICKS, 16'd2);
    push_beat(ACT_TICK, 8'h00);
    settle();
    no_gaps = 1'b0;

    // Random phases, each on its own register setting, written while idle.
    for (p = 0; p < 18; p++) begin
      case (p)
        0: begin cls = 8'h00; id = 8'h00; tmo = 16'h0000; end
        1: begin cls = 8'hFF; id = 8'hFF; tmo = 16'hFFFF; end
        2: begin cls = SYNC_1; id = SYNC_2; tmo = 16'd1; end
        default: begin
          cls = 8'($urandom);
          id = 8'($urandom);
          tmo = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        end
      endcase
      write_reg(REG_ACKED_CLASS, {8'($urandom), cls});
      write_reg(REG_ACKED_ID, {8'($urandom), id});
      write_reg(REG_TIMEOUT_TICKS, tmo);
      if (p % 5 == 2) write_reg(REG_NONE, 16'($urandom));
      gen_traffic(105);
      settle();
    end

    repeat (8) @(negedge clk);
    if (mismatch_cnt == 0 && pending_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #8000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
